[design/assert_macros.svh]
// Assertion helpers shared by the front-end and back-end design files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Check a property on every clock edge outside reset.
`define CHK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
// Check a property, including during reset.
`define CHK_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) (prop)) else $error(msg);
`endif

[design/smeu_pkg.sv]
`timescale 1ns / 1ps
package smeu_pkg;
	localparam logic [4:0] OP_ADD  = 5'd0;
	localparam logic [4:0] OP_SUB  = 5'd1;
	localparam logic [4:0] OP_MUL  = 5'd2;
	localparam logic [4:0] OP_DIV  = 5'd3;
	localparam logic [4:0] OP_OUT  = 5'd4;
	localparam logic [4:0] OP_IN   = 5'd5;
	localparam logic [4:0] OP_DUMP = 5'd6;
	localparam logic [4:0] OP_HLT  = 5'd7;
	localparam logic [4:0] OP_PUSH = 5'd8;
	localparam logic [4:0] OP_POP  = 5'd9;
	localparam logic [4:0] OP_JMP  = 5'd10;
	localparam logic [4:0] OP_CALL = 5'd11;
	localparam logic [4:0] OP_RET  = 5'd12;
	localparam logic [4:0] OP_JA   = 5'd13;
	localparam logic [4:0] OP_JAE  = 5'd14;
	localparam logic [4:0] OP_JB   = 5'd15;
	localparam logic [4:0] OP_JBE  = 5'd16;
	localparam logic [4:0] OP_JE   = 5'd17;
	localparam logic [4:0] OP_JNE  = 5'd18;

	localparam logic [2:0] ERR_NONE     = 3'd0;
	localparam logic [2:0] ERR_DIVZERO  = 3'd1;
	localparam logic [2:0] ERR_UNDER    = 3'd2;
	localparam logic [2:0] ERR_OVER     = 3'd3;
	localparam logic [2:0] ERR_ADDR     = 3'd4;
	localparam logic [2:0] ERR_POPARG   = 3'd5;
	localparam logic [2:0] ERR_EMPTYRET = 3'd6;
	localparam logic [2:0] ERR_UNKNOWN  = 3'd7;

	localparam logic [2:0] FLAG_MEM = 3'b100;
	localparam logic [2:0] FLAG_REG = 3'b010;

	// Instruction class decided by the front end.
	localparam logic [2:0] CL_ARITH = 3'd0;
	localparam logic [2:0] CL_SIMPLE = 3'd1;
	localparam logic [2:0] CL_PUSH  = 3'd2;
	localparam logic [2:0] CL_POP   = 3'd3;
	localparam logic [2:0] CL_FLOW  = 3'd4;
	localparam logic [2:0] CL_COND  = 3'd5;
	localparam logic [2:0] CL_BAD   = 3'd6;

	localparam int INSTR_BITS = 80;

	typedef struct packed {
		logic [4:0]  op;
		logic [2:0]  flags;
		logic [31:0] imm;
		logic [3:0]  ridx;
		logic [31:0] inval;
		logic [2:0]  cls;
		logic [2:0]  argl;
	} instr_t;

	typedef struct packed {
		logic [15:0] next_ip;
		logic [31:0] out_value;
		logic        out_valid;
		logic        halted;
		logic [2:0]  error_code;
	} result_t;
endpackage

[design/smeu_front.sv]
`timescale 1ns / 1ps
module smeu_front import smeu_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [4:0]  op,
	input  logic [2:0]  flags,
	input  logic [31:0] imm,
	input  logic [3:0]  ridx,
	input  logic [31:0] inval,
	output logic        q_valid,
	input  logic        q_ready,
	output instr_t      q_data
);
	instr_t cls_d;
	instr_t fifo_q [2];
	logic [1:0] cnt_q;
	logic       wr_q, rd_q;
	logic       push, pop;

	always_comb begin
		cls_d.op = op;
		cls_d.flags = flags;
		cls_d.imm = imm;
		cls_d.ridx = ridx;
		cls_d.inval = inval;
		cls_d.argl = 3'd2 + {2'b00, flags[0]} + {2'b00, flags[1]};
		if (op inside {OP_ADD, OP_SUB, OP_MUL, OP_DIV}) cls_d.cls = CL_ARITH;
		else if (op inside {OP_OUT, OP_IN, OP_DUMP, OP_HLT}) cls_d.cls = CL_SIMPLE;
		else if (op == OP_PUSH) cls_d.cls = CL_PUSH;
		else if (op == OP_POP) cls_d.cls = CL_POP;
		else if (op inside {OP_JMP, OP_CALL, OP_RET}) cls_d.cls = CL_FLOW;
		else if (op inside {[OP_JA:OP_JNE]}) cls_d.cls = CL_COND;
		else cls_d.cls = CL_BAD;
	end

	assign in_ready = (cnt_q != 2'd2);
	assign q_valid  = (cnt_q != 2'd0);
	assign q_data   = fifo_q[rd_q];
	assign push = in_valid && in_ready;
	assign pop  = q_valid && q_ready;

	always_ff @(posedge clk) begin
		if (push) fifo_q[wr_q] <= cls_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			wr_q <= 1'b0;
			rd_q <= 1'b0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (pop) rd_q <= ~rd_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	`include "assert_macros.svh"
	`CHK(a_no_over, (cnt_q == 2'd2) |-> !push, "queue overfilled")
	`CHK(a_cnt_range, cnt_q != 2'd3, "queue count out of range")
	`CHK(a_empty_ptrs, (cnt_q == 2'd0) |-> (wr_q == rd_q), "queue pointers disagree")
endmodule

[design/smeu_divider.sv]
`timescale 1ns / 1ps
module smeu_divider (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] dividend,
	input  logic [31:0] divisor,
	output logic        busy,
	output logic        done,
	output logic [31:0] quotient
);
	logic [31:0] rem_q, quo_q, dvs_q;
	logic [5:0]  cnt_q;
	logic        neg_q, busy_q, done_q;
	logic [32:0] trial;
	logic [31:0] shifted;

	assign shifted = {rem_q[30:0], quo_q[31]};
	assign trial = {1'b0, shifted} - {1'b0, dvs_q};
	assign busy = busy_q;
	assign done = done_q;
	assign quotient = neg_q ? (32'd0 - quo_q) : quo_q;

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend[31] ? (32'd0 - dividend) : dividend;
			dvs_q <= divisor[31] ? (32'd0 - divisor) : divisor;
			neg_q <= dividend[31] ^ divisor[31];
		end else if (busy_q) begin
			if (!trial[32]) begin
				rem_q <= trial[31:0];
				quo_q <= {quo_q[30:0], 1'b1};
			end else begin
				rem_q <= shifted;
				quo_q <= {quo_q[30:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd31) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end
endmodule

[design/smeu_back.sv]
`timescale 1ns / 1ps
module smeu_back import smeu_pkg::*; #(
	parameter int DATA_STACK_DEPTH = 64,
	parameter int CALL_STACK_DEPTH = 32,
	parameter int NUM_REGISTERS = 8,
	parameter int RAM_WORDS = 1024,
	parameter int CODE_ADDR_BITS = 16
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    q_valid,
	output logic    q_ready,
	input  instr_t  q_data,
	output logic    res_valid,
	input  logic    res_ready,
	output result_t res_data
);
	localparam int DSW = $clog2(DATA_STACK_DEPTH);
	localparam int CSW = $clog2(CALL_STACK_DEPTH);
	localparam int RW  = $clog2(NUM_REGISTERS);
	localparam int MW  = $clog2(RAM_WORDS);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_RD   = 3'd1;
	localparam logic [2:0] S_EXEC = 3'd2;
	localparam logic [2:0] S_DIV  = 3'd3;
	localparam logic [2:0] S_WB   = 3'd4;
	localparam logic [2:0] S_OUT  = 3'd5;

	logic [2:0] state_q;
	instr_t     ins_q;
	logic [31:0] ip_q;
	logic [DSW:0] dcnt_q;
	logic [CSW:0] ccnt_q;
	logic        halt_q;
	logic [2:0]  err_q;
	logic [31:0] regs_q [NUM_REGISTERS];
	logic [31:0] dstk [DATA_STACK_DEPTH];
	logic [CODE_ADDR_BITS-1:0] cstk [CALL_STACK_DEPTH];
	logic [31:0] ram [RAM_WORDS];
	logic        clr_q;
	logic [MW-1:0] clr_idx_q;
	logic [31:0] top_q, sec_q, ram_rd_q, sum_q, res_q;
	logic [CODE_ADDR_BITS-1:0] ret_q;
	logic        sum_ok_q;
	logic [31:0] outv_q;
	logic        outok_q;
	result_t     res_q_out;
	logic        res_valid_q;

	// register operand term
	logic [3:0]  mag;
	logic [31:0] rterm, sum_d;
	logic        sum_ok_d, ram_ok;
	assign mag = ins_q.ridx[3] ? (4'd0 - ins_q.ridx) : ins_q.ridx;
	always_comb begin
		rterm = '0;
		sum_ok_d = 1'b1;
		if ({28'd0, mag} >= NUM_REGISTERS) sum_ok_d = 1'b0;
		else rterm = regs_q[RW'(mag)];
		sum_d = ins_q.flags[0] ? ins_q.imm : 32'd0;
		if (ins_q.flags[1]) sum_d = ins_q.ridx[3] ? sum_d - rterm : sum_d + rterm;
		if (!ins_q.flags[1]) sum_ok_d = 1'b1;
	end
	assign ram_ok = !sum_q[31] && (sum_q < RAM_WORDS);

	logic        dv_start, dv_busy, dv_done;
	logic [31:0] dv_quo;
	smeu_divider u_div (
		.clk, .arst_n, .start(dv_start), .dividend(sec_q), .divisor(top_q),
		.busy(dv_busy), .done(dv_done), .quotient(dv_quo)
	);

	// execute decision
	logic [2:0]  e_err;
	logic [31:0] e_next;
	logic        e_hlt, e_wr_d, e_wr_c, e_wr_r, e_wr_m;
	logic [31:0] e_val;
	logic [DSW:0] e_dcnt;
	logic [CSW:0] e_ccnt;
	logic        take;
	logic signed [31:0] sx, sy;
	always_comb begin
		sx = sec_q;
		sy = top_q;
		e_err = ERR_NONE; e_hlt = 1'b0;
		e_next = ip_q + 32'd1;
		e_wr_d = 1'b0; e_wr_c = 1'b0; e_wr_r = 1'b0; e_wr_m = 1'b0;
		e_val = '0; e_dcnt = dcnt_q; e_ccnt = ccnt_q;
		case (ins_q.op)
			OP_JA:  take = sx > sy;
			OP_JAE: take = sx >= sy;
			OP_JB:  take = sx < sy;
			OP_JBE: take = sx <= sy;
			OP_JE:  take = sx == sy;
			default: take = sx != sy;
		endcase
		case (ins_q.op)
			OP_ADD, OP_SUB, OP_MUL: begin
				if (dcnt_q < 2) e_err = ERR_UNDER;
				else begin
					e_dcnt = dcnt_q - 1'b1;
					e_wr_d = 1'b1;
					e_val = (ins_q.op == OP_ADD) ? sec_q + top_q :
						(ins_q.op == OP_SUB) ? sec_q - top_q : res_q;
				end
			end
			OP_DIV: begin
				if (dcnt_q < 2) e_err = ERR_UNDER;
				else if (top_q == 0) e_err = ERR_DIVZERO;
				else begin
					e_dcnt = dcnt_q - 1'b1;
					e_wr_d = 1'b1;
					e_val = res_q;
				end
			end
			OP_OUT: begin
				if (dcnt_q == 0) e_err = ERR_UNDER;
				else e_dcnt = dcnt_q - 1'b1;
			end
			OP_IN: begin
				if (dcnt_q >= DATA_STACK_DEPTH) e_err = ERR_OVER;
				else begin
					e_dcnt = dcnt_q + 1'b1; e_wr_d = 1'b1; e_val = ins_q.inval;
				end
			end
			OP_DUMP: ;
			OP_HLT: e_hlt = 1'b1;
			OP_PUSH: begin
				if (!sum_ok_q) e_err = ERR_ADDR;
				else if (ins_q.flags[2] && !ram_ok) e_err = ERR_ADDR;
				else if (dcnt_q >= DATA_STACK_DEPTH) e_err = ERR_OVER;
				else begin
					e_dcnt = dcnt_q + 1'b1; e_wr_d = 1'b1;
					e_val = ins_q.flags[2] ? ram_rd_q : sum_q;
					e_next = ip_q + {29'd0, ins_q.argl};
				end
			end
			OP_POP: begin
				e_next = ip_q + {29'd0, ins_q.argl};
				if (ins_q.flags[2]) begin
					if (!sum_ok_q || !ram_ok) e_err = ERR_ADDR;
					else if (dcnt_q == 0) e_err = ERR_UNDER;
					else begin e_dcnt = dcnt_q - 1'b1; e_wr_m = 1'b1; e_val = top_q; end
				end else if (ins_q.flags == FLAG_REG) begin
					if (ins_q.ridx[3] || {28'd0, ins_q.ridx} >= NUM_REGISTERS) e_err = ERR_ADDR;
					else if (dcnt_q == 0) e_err = ERR_UNDER;
					else begin e_dcnt = dcnt_q - 1'b1; e_wr_r = 1'b1; e_val = top_q; end
				end else if (ins_q.flags == 3'd0) begin
					if (dcnt_q == 0) e_err = ERR_UNDER;
					else e_dcnt = dcnt_q - 1'b1;
				end else e_err = ERR_POPARG;
			end
			OP_JMP: begin
				if (!sum_ok_q) e_err = ERR_ADDR;
				else e_next = sum_q;
			end
			OP_CALL: begin
				if (ccnt_q >= CALL_STACK_DEPTH) e_err = ERR_OVER;
				else begin
					e_ccnt = ccnt_q + 1'b1; e_wr_c = 1'b1;
					e_val = ip_q + 32'd3; e_next = ins_q.imm;
				end
			end
			OP_RET: begin
				if (ccnt_q == 0) e_err = ERR_EMPTYRET;
				else begin e_ccnt = ccnt_q - 1'b1; e_next = 32'(ret_q); end
			end
			OP_JA, OP_JAE, OP_JB, OP_JBE, OP_JE, OP_JNE: begin
				if (dcnt_q < 2) e_err = ERR_UNDER;
				else if (!sum_ok_q) e_err = ERR_ADDR;
				else begin
					e_dcnt = dcnt_q - 2'd2;
					e_next = take ? sum_q : ip_q + {29'd0, ins_q.argl};
				end
			end
			default: e_err = ERR_UNKNOWN;
		endcase
		if (CODE_ADDR_BITS < 32) e_next = e_next & ((32'd1 << CODE_ADDR_BITS) - 32'd1);
	end

	logic [DSW-1:0] t_idx, s_idx, w_idx;
	assign t_idx = DSW'(dcnt_q - 1'b1);
	assign s_idx = DSW'(dcnt_q - 2'd2);
	assign w_idx = (ins_q.op == OP_IN || ins_q.op == OP_PUSH) ? DSW'(dcnt_q) : s_idx;
	assign dv_start = (state_q == S_EXEC) && ins_q.op == OP_DIV && dcnt_q >= 2 &&
		top_q != 0 && !dv_busy && !dv_done && !halt_q;

	// stack and memory reads and writes, multiply and divide results
	always_ff @(posedge clk) begin
		if (state_q == S_RD) begin
			top_q <= dstk[t_idx];
			sec_q <= dstk[s_idx];
			ret_q <= cstk[CSW'(ccnt_q - 1'b1)];
			ram_rd_q <= ram[sum_d[MW-1:0]];
			sum_q <= sum_d;
			sum_ok_q <= sum_ok_d;
		end
		if (state_q == S_DIV) res_q <= dv_quo;
		else if (state_q == S_EXEC) res_q <= sec_q * top_q;
		if (state_q == S_WB && e_err == ERR_NONE) begin
			if (e_wr_d) dstk[w_idx] <= e_val;
			if (e_wr_c) cstk[CSW'(ccnt_q)] <= e_val[CODE_ADDR_BITS-1:0];
		end
		// zero the RAM word by word after reset, then take stores
		if (clr_q) ram[clr_idx_q] <= '0;
		else if (state_q == S_WB && e_err == ERR_NONE && e_wr_m) ram[sum_q[MW-1:0]] <= e_val;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ins_q <= '0;
			ip_q <= '0; dcnt_q <= '0; ccnt_q <= '0;
			halt_q <= 1'b0; err_q <= ERR_NONE;
			clr_q <= 1'b1;
			clr_idx_q <= '0;
			outok_q <= 1'b0;
			outv_q <= '0;
			res_q_out <= '0;
			res_valid_q <= 1'b0;
			for (int i = 0; i < NUM_REGISTERS; i++) regs_q[i] <= '0;
		end else begin
			if (clr_q) begin
				clr_idx_q <= clr_idx_q + 1'b1;
				if (clr_idx_q == MW'(RAM_WORDS - 1)) clr_q <= 1'b0;
			end
			if (state_q == S_OUT && (!res_valid_q || res_ready)) res_valid_q <= 1'b1;
			else if (res_ready) res_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: if (q_valid && !clr_q) begin
					ins_q <= q_data;
					state_q <= S_RD;
				end
				S_RD: state_q <= halt_q ? S_OUT : S_EXEC;
				S_EXEC: state_q <= dv_start ? S_DIV : S_WB;
				S_DIV: if (dv_done) state_q <= S_WB;
				S_WB: begin
					if (e_err != ERR_NONE) begin
						halt_q <= 1'b1; err_q <= e_err;
						outok_q <= 1'b0;
					end else begin
						ip_q <= e_next; dcnt_q <= e_dcnt; ccnt_q <= e_ccnt;
						if (e_hlt) halt_q <= 1'b1;
						if (e_wr_r) regs_q[RW'(ins_q.ridx)] <= e_val;
						outok_q <= ins_q.op == OP_OUT;
						outv_q <= top_q;
					end
					state_q <= S_OUT;
				end
				S_OUT: if (!res_valid_q || res_ready) begin
					res_q_out.next_ip <= ip_q[15:0];
					res_q_out.out_value <= outok_q ? outv_q : 32'd0;
					res_q_out.out_valid <= outok_q;
					res_q_out.halted <= halt_q;
					res_q_out.error_code <= err_q;
					outok_q <= 1'b0;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign q_ready = (state_q == S_IDLE) && !clr_q;
	assign res_valid = res_valid_q;
	assign res_data = res_q_out;

	`include "assert_macros.svh"
	`CHK(a_dcnt, dcnt_q <= DATA_STACK_DEPTH, "data stack count past depth")
	`CHK(a_ccnt, ccnt_q <= CALL_STACK_DEPTH, "call stack count past depth")
	`CHK(a_halt_sticky, halt_q |=> halt_q, "halt flag cleared")
	`CHK(a_div_state, (state_q == S_DIV) |-> (dv_busy || dv_done), "divide state without divider")
endmodule

[design/stack_machine_execute_unit_core.sv]
`timescale 1ns / 1ps
// Execute unit of a 32-bit stack machine. Each word on s_axis is one fetched
// instruction; each word on m_axis reports the next fetch address, any out
// value, the halted flag and the latched error. A front end classifies the
// instruction and parks it in a two-entry queue; the back end executes one
// instruction at a time through idle, read, execute, write-back and report
// states, with a divide state between execute and write-back for div (serial
// divider, one quotient bit per cycle); once halted it goes from read straight
// to report. A report held back by m_axis_tready stalls the back end in
// its report state; the queue then fills and s_axis_tready drops. Errors and
// hlt halt the machine for good; afterwards every instruction just reports
// the frozen state. After reset the back end zeroes the data RAM word by word
// (RAM_WORDS words, 1024 by default) before it takes its first instruction;
// the front end still accepts two words meanwhile.
module stack_machine_execute_unit_core import smeu_pkg::*; #(
	parameter int DATA_STACK_DEPTH = 64,
	parameter int CALL_STACK_DEPTH = 32,
	parameter int NUM_REGISTERS = 8,
	parameter int RAM_WORDS = 1024,
	parameter int CODE_ADDR_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// operation[4:0], arg_flags[7:5], immediate[39:8], reg_operand[43:40],
	// input_value[75:44], zero fill
	input  logic [79:0] s_axis_tdata,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// next_ip[15:0], out_value[47:16], out_valid[48], halted[49],
	// error_code[52:50], zero fill
	output logic [55:0] m_axis_tdata
);
	logic   q_valid, q_ready;
	instr_t q_data;
	result_t res;

	// front: accept and classify
	smeu_front u_front (
		.clk, .arst_n,
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.op(s_axis_tdata[4:0]), .flags(s_axis_tdata[7:5]), .imm(s_axis_tdata[39:8]),
		.ridx(s_axis_tdata[43:40]), .inval(s_axis_tdata[75:44]),
		.q_valid, .q_ready, .q_data
	);

	// back: execute and report
	smeu_back #(
		.DATA_STACK_DEPTH(DATA_STACK_DEPTH), .CALL_STACK_DEPTH(CALL_STACK_DEPTH),
		.NUM_REGISTERS(NUM_REGISTERS), .RAM_WORDS(RAM_WORDS),
		.CODE_ADDR_BITS(CODE_ADDR_BITS)
	) u_back (
		.clk, .arst_n, .q_valid, .q_ready, .q_data,
		.res_valid(m_axis_tvalid), .res_ready(m_axis_tready), .res_data(res)
	);

	assign m_axis_tdata = {3'd0, res.error_code, res.halted, res.out_valid,
		res.out_value, res.next_ip};
endmodule

[tb/tb.sv]
`timescale 1ns / 1ps
module tb;
	import smeu_pkg::*;

	localparam int LIMIT = 1000000;
	localparam int N_RANDOM = 1600;
	localparam int DS_DEPTH = 64;
	localparam int RS_DEPTH = 32;
	localparam int N_REGS = 8;
	localparam int RAM_SIZE = 1024;

	typedef struct {
		logic [4:0]  op;
		logic [2:0]  flags;
		logic [31:0] imm;
		logic [3:0]  ridx;
		logic [31:0] inval;
	} stim_t;

	typedef struct {
		logic [15:0] next_ip;
		logic [31:0] out_value;
		logic        out_valid;
		logic        halted;
		logic [2:0]  error_code;
	} report_t;

	// Machine model plus the queue of reports still owed by the core.
	class exec_scoreboard;
		logic [15:0] ip;
		logic [31:0] dstack[DS_DEPTH];
		int          dcount;
		logic [15:0] rstack[RS_DEPTH];
		int          rcount;
		logic [31:0] regs[N_REGS];
		logic [31:0] ram[RAM_SIZE];
		bit          stopped;
		logic [2:0]  err_latch;
		report_t     owed[$];
		int          mismatches, reports, outs, taken, not_taken, calls;

		function new();
			ip = 0; dcount = 0; rcount = 0; stopped = 0; err_latch = ERR_NONE;
			foreach (regs[i]) regs[i] = 0;
			foreach (ram[i]) ram[i] = 0;
		endfunction

		// Signed register term: negative index subtracts the register.
		function bit reg_term(logic [3:0] ridx, output logic [31:0] t);
			int r, mag;
			r = $signed(ridx);
			mag = r < 0 ? -r : r;
			t = 0;
			if (mag >= N_REGS) return 0;
			t = r < 0 ? -regs[mag] : regs[mag];
			return 1;
		endfunction

		function bit operand(logic [2:0] flags, logic [31:0] imm, logic [3:0] ridx,
				output logic [31:0] s);
			logic [31:0] t;
			s = flags[0] ? imm : 32'd0;
			if (flags[1]) begin
				if (!reg_term(ridx, t)) return 0;
				s = s + t;
			end
			return 1;
		endfunction

		function void note_instr(stim_t it);
			report_t rp;
			logic [15:0] nxt;
			logic [2:0] e;
			logic [31:0] a, b, r, s, outv;
			bit outok, hlt, take;
			int argl, ri;
			rp.out_value = 0;
			rp.out_valid = 0;
			if (stopped) begin
				rp.next_ip = ip; rp.halted = 1; rp.error_code = err_latch;
				owed.push_back(rp);
				return;
			end
			argl = 2 + it.flags[0] + it.flags[1];
			nxt = ip + 16'd1;
			e = ERR_NONE; outv = 0; outok = 0; hlt = 0;
			case (it.op)
			OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
				if (dcount < 2) e = ERR_UNDER;
				else begin
					b = dstack[dcount-1];
					a = dstack[dcount-2];
					if (it.op == OP_ADD) r = a + b;
					else if (it.op == OP_SUB) r = a - b;
					else if (it.op == OP_MUL) r = a * b;
					else if (b == 0) e = ERR_DIVZERO;
					else if (a == 32'h8000_0000 && b == 32'hFFFF_FFFF) r = a;
					else r = $signed(a) / $signed(b);
					if (e == ERR_NONE) begin
						dcount--;
						dstack[dcount-1] = r;
					end
				end
			end
			OP_OUT: begin
				if (dcount == 0) e = ERR_UNDER;
				else begin
					dcount--;
					outv = dstack[dcount];
					outok = 1;
				end
			end
			OP_IN: begin
				if (dcount >= DS_DEPTH) e = ERR_OVER;
				else dstack[dcount++] = it.inval;
			end
			OP_DUMP: ;
			OP_HLT: hlt = 1;
			OP_PUSH: begin
				if (!operand(it.flags, it.imm, it.ridx, s)) e = ERR_ADDR;
				else if (it.flags[2] && s >= RAM_SIZE) e = ERR_ADDR;
				else begin
					if (it.flags[2]) s = ram[s];
					if (dcount >= DS_DEPTH) e = ERR_OVER;
					else begin
						dstack[dcount++] = s;
						nxt = ip + 16'(argl);
					end
				end
			end
			OP_POP: begin
				ri = $signed(it.ridx);
				if (it.flags[2]) begin
					if (!operand(it.flags, it.imm, it.ridx, s) || s >= RAM_SIZE)
						e = ERR_ADDR;
					else if (dcount == 0) e = ERR_UNDER;
					else ram[s] = dstack[--dcount];
				end else if (it.flags == FLAG_REG) begin
					if (ri < 0 || ri >= N_REGS) e = ERR_ADDR;
					else if (dcount == 0) e = ERR_UNDER;
					else regs[ri] = dstack[--dcount];
				end else if (it.flags == 3'b000) begin
					if (dcount == 0) e = ERR_UNDER;
					else dcount--;
				end else e = ERR_POPARG;
				if (e == ERR_NONE) nxt = ip + 16'(argl);
			end
			OP_JMP: begin
				if (!operand(it.flags, it.imm, it.ridx, s)) e = ERR_ADDR;
				else nxt = s[15:0];
			end
			OP_CALL: begin
				if (rcount >= RS_DEPTH) e = ERR_OVER;
				else begin
					rstack[rcount++] = ip + 16'd3;
					nxt = it.imm[15:0];
					calls++;
				end
			end
			OP_RET: begin
				if (rcount == 0) e = ERR_EMPTYRET;
				else nxt = rstack[--rcount];
			end
			OP_JA, OP_JAE, OP_JB, OP_JBE, OP_JE, OP_JNE: begin
				if (dcount < 2) e = ERR_UNDER;
				else if (!operand(it.flags, it.imm, it.ridx, s)) e = ERR_ADDR;
				else begin
					b = dstack[dcount-1];
					a = dstack[dcount-2];
					case (it.op)
					OP_JA:  take = $signed(a) > $signed(b);
					OP_JAE: take = $signed(a) >= $signed(b);
					OP_JB:  take = $signed(a) < $signed(b);
					OP_JBE: take = $signed(a) <= $signed(b);
					OP_JE:  take = a == b;
					default: take = a != b;
					endcase
					dcount -= 2;
					nxt = take ? s[15:0] : ip + 16'(argl);
					if (take) taken++; else not_taken++;
				end
			end
			default: e = ERR_UNKNOWN;
			endcase
			if (e != ERR_NONE) begin
				stopped = 1;
				err_latch = e;
				outv = 0;
				outok = 0;
			end else begin
				ip = nxt;
				if (hlt) stopped = 1;
			end
			if (outok) outs++;
			rp.next_ip = ip; rp.out_value = outv; rp.out_valid = outok;
			rp.halted = stopped; rp.error_code = err_latch;
			owed.push_back(rp);
		endfunction

		function void check_report(logic [55:0] d);
			report_t w, got;
			got.next_ip = d[15:0]; got.out_value = d[47:16]; got.out_valid = d[48];
			got.halted = d[49]; got.error_code = d[52:50];
			reports++;
			if (owed.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected report %h", d);
				return;
			end
			w = owed.pop_front();
			if (got.next_ip !== w.next_ip || got.out_value !== w.out_value ||
					got.out_valid !== w.out_valid || got.halted !== w.halted ||
					got.error_code !== w.error_code || d[55:53] !== 3'b000) begin
				mismatches++;
				if (mismatches <= 10)
					$display("report %0d: exp ip=%h out=%h/%b halt=%b err=%0d, got %h",
						reports, w.next_ip, w.out_value, w.out_valid, w.halted,
						w.error_code, d);
			end
		endfunction
	endclass

	logic        clk = 0;
	logic        arst_n = 0;
	logic        s_axis_tvalid = 0;
	logic        s_axis_tready;
	logic [79:0] s_axis_tdata = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 0;
	logic [55:0] m_axis_tdata;

	exec_scoreboard sb = new();
	bit calm = 0;       // no random idling on either side
	int sent = 0;
	int hold_left = 0;
	bit hold_done = 0;
	int cycles = 0;

	stack_machine_execute_unit_core u_dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("Some tests failed");
			$finish;
		end
	end

	// Report side: check, then pick the next ready; one long hold-off early on.
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) sb.check_report(m_axis_tdata);
		if (!hold_done && sent >= 300) begin
			hold_done <= 1;
			hold_left <= 400;
			m_axis_tready <= 0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			m_axis_tready <= 0;
		end else
			m_axis_tready <= arst_n && (calm || $urandom_range(0, 99) >= 34);
	end

	task automatic send_instr(stim_t it);
		while (!calm && $urandom_range(0, 99) < 34) begin
			s_axis_tvalid <= 0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1;
		s_axis_tdata <= {4'b0, it.inval, it.ridx, it.imm, it.flags, it.op};
		do @(posedge clk); while (!s_axis_tready);
		sb.note_instr(it);
		sent++;
	endtask

	task automatic send_op(logic [4:0] op, logic [2:0] flags, logic [31:0] imm,
			logic [3:0] ridx, logic [31:0] inval);
		stim_t it;
		it.op = op; it.flags = flags; it.imm = imm; it.ridx = ridx; it.inval = inval;
		send_instr(it);
	endtask

	function automatic logic [3:0] any_reg();
		return 4'($signed($urandom_range(0, 14)) - 7);
	endfunction

	function automatic logic [31:0] pick_value();
		case ($urandom_range(0, 5))
		0: return 32'h8000_0000;
		1: return 32'h7FFF_FFFF;
		2, 3: return 32'($signed($urandom_range(0, 8)) - 4);
		default: return $urandom;
		endcase
	endfunction

	// Fill in an operand whose sum lands on a legal RAM word.
	function automatic void ram_operand(inout stim_t it);
		logic [31:0] t, target;
		target = $urandom_range(0, 3) == 0 ? $urandom_range(0, RAM_SIZE - 1)
			: $urandom_range(0, 15);
		it.flags[2] = 1;
		t = 0;
		if (it.flags[1]) void'(sb.reg_term(it.ridx, t));
		if (!it.flags[0] && t != target && (it.flags[1] || target != 0))
			it.flags[0] = 1;
		if (it.flags[0]) it.imm = target - t;
	endfunction

	// Draw a random instruction that keeps the machine running.
	function automatic stim_t legal_instr();
		stim_t it;
		int w;
		it.imm = $urandom; it.inval = pick_value(); it.ridx = any_reg();
		it.flags = 3'($urandom_range(0, 7));
		w = $urandom_range(0, 99);
		if (sb.dcount < 4) w = $urandom_range(0, 1) ? 30 : 40;
		else if (sb.dcount > DS_DEPTH - 8) w = $urandom_range(0, 1) ? 10 : 90;
		if (w < 25) begin
			it.op = 5'($urandom_range(0, 3));
			if (it.op == OP_DIV && sb.dstack[sb.dcount-1] == 0) it.op = OP_SUB;
		end else if (w < 30) it.op = OP_OUT;
		else if (w < 35) it.op = OP_IN;
		else if (w < 37) it.op = OP_DUMP;
		else if (w < 55) begin
			it.op = OP_PUSH;
			if (it.flags[0] && !it.flags[2]) it.imm = pick_value();
			if (it.flags[2]) ram_operand(it);
		end else if (w < 67) begin
			it.op = OP_POP;
			case ($urandom_range(0, 2))
			0: it.flags = 3'b000;
			1: begin
				it.flags = FLAG_REG;
				it.ridx = 4'($urandom_range(0, N_REGS - 1));
			end
			default: begin
				it.flags = FLAG_MEM | 3'($urandom_range(0, 3));
				ram_operand(it);
			end
			endcase
		end else if (w < 72) it.op = OP_JMP;
		else if (w < 82) begin
			it.op = (w < 77) ? OP_CALL : OP_RET;
			if (sb.rcount == 0) it.op = OP_CALL;
			if (sb.rcount >= RS_DEPTH) it.op = OP_RET;
		end else it.op = 5'($urandom_range(OP_JA, OP_JNE));
		return it;
	endfunction

	initial begin
		stim_t it;
		int pick;
		repeat (2) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed: wraps, div corner cases, negated register, RAM, flow.
		send_op(OP_PUSH, 3'b001, 32'h7FFF_FFFF, 4'd0, 32'd0);
		send_op(OP_PUSH, 3'b001, 32'h8000_0000, 4'd0, 32'd0);
		send_op(OP_ADD, 3'b000, 32'd0, 4'd0, 32'd0);
		send_op(OP_IN, 3'b000, 32'd0, 4'd0, 32'h8000_0000);
		send_op(OP_MUL, 3'b000, 32'd0, 4'd0, 32'd0);
		send_op(OP_PUSH, 3'b001, 32'hFFFF_FFFF, 4'd0, 32'd0);
		send_op(OP_DIV, 3'b000, 32'd0, 4'd0, 32'd0);
		send_op(OP_PUSH, 3'b001, 32'd7, 4'd0, 32'd0);
		send_op(OP_PUSH, 3'b001, 32'hFFFF_FFFE, 4'd0, 32'd0);
		send_op(OP_DIV, 3'b000, 32'd0, 4'd0, 32'd0);
		send_op(OP_POP, FLAG_REG, 32'd0, 4'd3, 32'd0);
		send_op(OP_PUSH, FLAG_REG, 32'd0, 4'b1101, 32'd0);
		send_op(OP_POP, 3'b101, 32'd9, 4'd0, 32'd0);
		send_op(OP_PUSH, 3'b101, 32'd9, 4'd0, 32'd0);
		send_op(OP_PUSH, 3'b100, 32'hFFFF_FFFF, 4'd7, 32'd0);
		send_op(OP_OUT, 3'b000, 32'd0, 4'd0, 32'd0);
		send_op(OP_DUMP, 3'b000, 32'd0, 4'd0, 32'd0);
		send_op(OP_PUSH, 3'b001, 32'd3, 4'd0, 32'd0);
		send_op(OP_JB, 3'b001, 32'h1234, 4'd0, 32'd0);
		send_op(OP_PUSH, 3'b001, 32'd5, 4'd0, 32'd0);
		send_op(OP_PUSH, 3'b001, 32'd5, 4'd0, 32'd0);
		send_op(OP_JNE, 3'b011, 32'd100, 4'b1001, 32'd0);
		send_op(OP_CALL, 3'b000, 32'hFFFF_0040, 4'd0, 32'd0);
		send_op(OP_RET, 3'b000, 32'd0, 4'd0, 32'd0);
		send_op(OP_JMP, 3'b111, 32'h0001_0020, 4'b1111, 32'd0);

		// Random legal traffic, with a calm stretch in the middle.
		for (int i = 0; i < N_RANDOM; i++) begin
			calm = (i >= 700 && i < 950);
			send_instr(legal_instr());
		end

		// Stop the machine one way, then show that the state stays frozen.
		pick = $urandom_range(0, 5);
		case (pick)
		0: send_op(OP_HLT, 3'b000, 32'd0, 4'd0, 32'd0);
		1: send_op(5'($urandom_range(19, 31)), 3'b000, 32'd0, 4'd0, 32'd0);
		2: send_op(OP_POP, 3'b011, 32'd0, 4'd1, 32'd0);
		3: send_op(OP_PUSH, FLAG_REG, 32'd0, 4'b1000, 32'd0);
		4: send_op(OP_PUSH, 3'b101, 32'd1024, 4'd0, 32'd0);
		default: begin
			send_op(OP_PUSH, 3'b001, 32'd0, 4'd0, 32'd0);
			send_op(OP_DIV, 3'b000, 32'd0, 4'd0, 32'd0);
		end
		endcase
		repeat (6) send_instr(legal_instr());
		s_axis_tvalid <= 0;

		while (sb.owed.size() != 0) @(posedge clk);
		repeat (80) @(posedge clk);

		$display("%0d instructions, %0d reports, %0d outs, %0d calls, %0d/%0d branches",
			sent, sb.reports, sb.outs, sb.calls, sb.taken, sb.not_taken);
		$display("stopped with error code %0d, %0d mismatches", sb.err_latch, sb.mismatches);
		if (sb.mismatches == 0 && sb.owed.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end
endmodule

[files.f]
+incdir+design
design/smeu_pkg.sv
design/smeu_front.sv
design/smeu_divider.sv
design/smeu_back.sv
design/stack_machine_execute_unit_core.sv
tb/tb.sv
